/* hdl/bqss_pkg.sv */
// shared types, constants and window classification for the bit-quad statistics block
package bqss_pkg;

   // field widths
   localparam int PIXEL_W      = 8;
   localparam int REGION_W     = 9;
   localparam int CNT_W        = 17;
   localparam int AREA_W       = 17;
   localparam int PERIM_W      = 18;
   localparam int EULER_W      = 16;

   // defaults and sizes
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int REGION_RESET    = 256;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_CLASSES     = 6;
   localparam int CLS_W           = 3;

   // window classes, also the counter index
   localparam logic [CLS_W-1:0] CLS_NONE     = 3'd0;
   localparam logic [CLS_W-1:0] CLS_ONE      = 3'd1;
   localparam logic [CLS_W-1:0] CLS_TWO_ADJ  = 3'd2;
   localparam logic [CLS_W-1:0] CLS_THREE    = 3'd3;
   localparam logic [CLS_W-1:0] CLS_FOUR     = 3'd4;
   localparam logic [CLS_W-1:0] CLS_DIAGONAL = 3'd5;

   // saturation limits
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // one classified request moving from front to back
   typedef struct packed {
      logic             last;
      logic             counted;
      logic [CLS_W-1:0] cls;
   } win_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // classify a 2x2 window of black bits
   function automatic logic [CLS_W-1:0] classify(input logic ul, input logic ur,
                                                 input logic ll, input logic lr);
      logic [2:0]       n;
      logic [CLS_W-1:0] c;
      n = 3'(ul) + 3'(ur) + 3'(ll) + 3'(lr);
      unique case (n)
         3'd0: c = CLS_NONE;
         3'd1: c = CLS_ONE;
         3'd2: c = ((ul && lr) || (ur && ll)) ? CLS_DIAGONAL : CLS_TWO_ADJ;
         3'd3: c = CLS_THREE;
         default: c = CLS_FOUR;
      endcase
      return c;
   endfunction

endpackage

/* hdl/bqss_ram.sv */
// generic single-write, single-read ram with registered read data
module bqss_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bqss_front.sv */
// front end: accepts pixels, keeps the line buffer and classifies each 2x2 window
module bqss_front #(
   parameter int MAX_COLUMNS = bqss_pkg::DEF_MAX_COLUMNS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [bqss_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic                          req_last_pixel,
   input  logic [bqss_pkg::REGION_W-1:0] region_columns,
   input  bqss_pkg::qstat_type           q_stat,
   output logic                          q_push,
   output bqss_pkg::win_type             q_entry
);
   import bqss_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int LW = ($clog2(MAX_COLUMNS + 1) > REGION_W) ?
                       $clog2(MAX_COLUMNS + 1) : REGION_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_COLUMNS);
   localparam logic [LW-1:0] MIN_LEN = LW'(2);

   logic [AW-1:0] col_ff, col_in;
   logic          first_row_ff, first_row_in;
   logic          left_cur_ff, left_cur_in;
   logic          left_prev_ff, left_prev_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_ok_ff;

   logic [LW-1:0] cols;
   logic [LW-1:0] rc_ext;
   logic [AW-1:0] eff_col;
   logic [AW-1:0] next_eff;
   logic          wrap;
   logic          accept;
   logic          black;
   logic          up;
   logic          rd_match;

   // clamp the row length to the supported range
   always_comb begin
      rc_ext = LW'(region_columns);
      priority if (rc_ext < MIN_LEN) begin
         cols = MIN_LEN;
      end else if (rc_ext > MAX_LEN) begin
         cols = MAX_LEN;
      end else begin
         cols = rc_ext;
      end
   end

   // column in use, and whether this pixel ends its row
   assign eff_col  = (LW'(col_ff) >= cols) ? '0 : col_ff;
   assign wrap     = (LW'(eff_col) + LW'(1)) >= cols;
   assign black    = (req_pixel == '0);
   assign rd_match = rd_ok_ff && (rd_addr_ff == eff_col);
   assign req_full = q_stat.full || !rd_match;
   assign accept   = req_push && !req_full;

   // next raster position
   always_comb begin
      col_in       = col_ff;
      first_row_in = first_row_ff;
      left_cur_in  = left_cur_ff;
      left_prev_in = left_prev_ff;
      if (accept) begin
         priority if (req_last_pixel) begin
            col_in       = '0;
            first_row_in = 1'b1;
            left_cur_in  = 1'b0;
            left_prev_in = 1'b0;
         end else if (wrap) begin
            col_in       = '0;
            first_row_in = 1'b0;
            left_cur_in  = 1'b0;
            left_prev_in = 1'b0;
         end else begin
            col_in       = eff_col + AW'(1);
            left_cur_in  = black;
            left_prev_in = up;
         end
      end
   end

   // prefetch the line buffer entry for the next pixel
   assign next_eff   = (LW'(col_in) >= cols) ? '0 : col_in;
   assign rd_addr_in = next_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         left_cur_ff  <= 1'b0;
         left_prev_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         left_cur_ff  <= left_cur_in;
         left_prev_ff <= left_prev_in;
         rd_ok_ff     <= 1'b1;
         rd_addr_ff   <= rd_addr_in;
      end
   end

   // one-bit line buffer holding the previous row
   bqss_ram #(
      .WIDTH (1),
      .DEPTH (MAX_COLUMNS)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (eff_col),
      .wr_data (black),
      .rd_addr (rd_addr_in),
      .rd_data (up)
   );

   // classified request toward the back end
   assign q_entry.last    = req_last_pixel;
   assign q_entry.counted = !first_row_ff && (eff_col != '0);
   assign q_entry.cls     = classify(left_prev_ff, up, left_cur_ff, black);
   assign q_push          = accept && (req_last_pixel || q_entry.counted);

endmodule

/* hdl/bqss_queue.sv */
// short queue of classified windows between front and back ends
module bqss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bqss_pkg::win_type   push_entry,
   input  logic                pop,
   output bqss_pkg::win_type   head,
   output bqss_pkg::qstat_type stat
);
   import bqss_pkg::*;

   win_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   // pointer and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/bqss_back.sv */
// back end: class counters and the result pipeline for area, perimeter and euler number
module bqss_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bqss_pkg::win_type             head,
   input  bqss_pkg::qstat_type           q_stat,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_none,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_one,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_two_adjacent,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_three,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_four,
   output logic [bqss_pkg::CNT_W-1:0]    rsp_count_diagonal,
   output logic [bqss_pkg::AREA_W-1:0]   rsp_area_estimate,
   output logic [bqss_pkg::PERIM_W-1:0]  rsp_perimeter_estimate,
   output logic signed [bqss_pkg::EULER_W-1:0] rsp_euler_number
);
   import bqss_pkg::*;

   localparam int SUM_W  = CNT_W + 3;
   localparam int AREA_SUM_W = CNT_W + 4;
   localparam int PSUM_W = CNT_W + 2;
   localparam int ESUM_W = CNT_W + 3;
   localparam logic [AREA_SUM_W-3:0] AREA_LIM = (AREA_SUM_W-2)'(CNT_MAX);
   localparam logic signed [ESUM_W-1:0] E_HI = ESUM_W'(32767);
   localparam logic signed [ESUM_W-1:0] E_LO = -ESUM_W'(32768);

   logic [CNT_W-1:0] cnt_ff   [NUM_CLASSES];
   logic [CNT_W-1:0] cnt_in   [NUM_CLASSES];
   logic [CNT_W-1:0] bumped   [NUM_CLASSES];

   // stage a: snapshot of the final counts
   logic             a_valid_ff, a_valid_in;
   logic [CNT_W-1:0] a_cnt_ff [NUM_CLASSES];

   // stage b: counts plus partial sums
   logic             b_valid_ff, b_valid_in;
   logic [CNT_W-1:0] b_cnt_ff [NUM_CLASSES];
   logic [SUM_W-1:0] b_s1_ff, b_s1_in;
   logic [SUM_W-1:0] b_s2_ff, b_s2_in;
   logic [PSUM_W-1:0] b_perim_ff, b_perim_in;
   logic signed [ESUM_W-1:0] b_esum_ff, b_esum_in;

   // stage c: result register
   logic             c_valid_ff, c_valid_in;
   logic [CNT_W-1:0] c_cnt_ff [NUM_CLASSES];
   logic [AREA_W-1:0]  c_area_ff, c_area_in;
   logic [PERIM_W-1:0] c_perim_ff, c_perim_in;
   logic signed [EULER_W-1:0] c_euler_ff, c_euler_in;

   logic c_free, b_adv, b_free, a_adv, a_ready;
   logic close_region;
   logic [AREA_SUM_W-1:0] area_sum;
   logic [AREA_SUM_W-3:0] area_q;
   logic signed [ESUM_W-1:0] e_adj;
   logic signed [ESUM_W-1:0] e_q;

   // pipeline flow
   assign c_free  = !c_valid_ff || rsp_pop;
   assign b_adv   = b_valid_ff && c_free;
   assign b_free  = !b_valid_ff || b_adv;
   assign a_adv   = a_valid_ff && b_free;
   assign a_ready = !a_valid_ff || a_adv;
   assign q_pop   = !q_stat.empty && (!head.last || a_ready);
   assign close_region = q_pop && head.last;

   // saturating class counters
   always_comb begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
         bumped[k] = (q_pop && head.counted && (head.cls == CLS_W'(k)) &&
                      (cnt_ff[k] != CNT_MAX)) ? cnt_ff[k] + CNT_W'(1) : cnt_ff[k];
         cnt_in[k] = close_region ? '0 : bumped[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // valid flags
   always_comb begin
      a_valid_in = close_region ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      b_valid_in = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      c_valid_in = b_adv ? 1'b1 : ((c_valid_ff && rsp_pop) ? 1'b0 : c_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // partial sums from the snapshot
   always_comb begin
      b_s1_in    = SUM_W'(a_cnt_ff[CLS_ONE]) + SUM_W'({a_cnt_ff[CLS_TWO_ADJ], 1'b0}) +
                   SUM_W'({a_cnt_ff[CLS_DIAGONAL], 1'b0});
      b_s2_in    = SUM_W'(a_cnt_ff[CLS_THREE]) + SUM_W'({a_cnt_ff[CLS_THREE], 1'b0}) +
                   SUM_W'({a_cnt_ff[CLS_FOUR], 2'b00});
      b_perim_in = PSUM_W'(a_cnt_ff[CLS_ONE]) + PSUM_W'(a_cnt_ff[CLS_TWO_ADJ]) +
                   PSUM_W'({a_cnt_ff[CLS_DIAGONAL], 1'b0});
      b_esum_in  = $signed(ESUM_W'(a_cnt_ff[CLS_ONE])) -
                   $signed(ESUM_W'(a_cnt_ff[CLS_THREE])) -
                   $signed(ESUM_W'({a_cnt_ff[CLS_DIAGONAL], 1'b0}));
   end

   // final division by four and saturation
   always_comb begin
      area_sum = AREA_SUM_W'(b_s1_ff) + AREA_SUM_W'(b_s2_ff);
      area_q   = area_sum[AREA_SUM_W-1:2];
      c_area_in = (area_q > AREA_LIM) ? CNT_MAX : AREA_W'(area_q);
      c_perim_in = (PSUM_W'(b_perim_ff) > PSUM_W'({PERIM_W{1'b1}})) ?
                   {PERIM_W{1'b1}} : PERIM_W'(b_perim_ff);
      e_adj = b_esum_ff[ESUM_W-1] ? b_esum_ff + ESUM_W'(3) : b_esum_ff;
      e_q   = e_adj >>> 2;
      priority if (e_q > E_HI) begin
         c_euler_in = EULER_W'(E_HI);
      end else if (e_q < E_LO) begin
         c_euler_in = EULER_W'(E_LO);
      end else begin
         c_euler_in = EULER_W'(e_q);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (close_region) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            a_cnt_ff[k] <= bumped[k];
         end
      end
      if (a_adv) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            b_cnt_ff[k] <= a_cnt_ff[k];
         end
         b_s1_ff    <= b_s1_in;
         b_s2_ff    <= b_s2_in;
         b_perim_ff <= b_perim_in;
         b_esum_ff  <= b_esum_in;
      end
      if (b_adv) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            c_cnt_ff[k] <= b_cnt_ff[k];
         end
         c_area_ff  <= c_area_in;
         c_perim_ff <= c_perim_in;
         c_euler_ff <= c_euler_in;
      end
   end

   // result ports
   assign rsp_empty              = !c_valid_ff;
   assign rsp_count_none         = c_cnt_ff[CLS_NONE];
   assign rsp_count_one          = c_cnt_ff[CLS_ONE];
   assign rsp_count_two_adjacent = c_cnt_ff[CLS_TWO_ADJ];
   assign rsp_count_three        = c_cnt_ff[CLS_THREE];
   assign rsp_count_four         = c_cnt_ff[CLS_FOUR];
   assign rsp_count_diagonal     = c_cnt_ff[CLS_DIAGONAL];
   assign rsp_area_estimate      = c_area_ff;
   assign rsp_perimeter_estimate = c_perim_ff;
   assign rsp_euler_number       = c_euler_ff;

endmodule

/* hdl/bit_quad_shape_statistics_top.sv */
// top level of the bit-quad shape statistics block
// Usage:
//   Pixels enter on the request queue (req_push/req_full) in row-major order, one
//   per cycle while req_full is low; a zero pixel is black. req_last_pixel marks
//   the final pixel of a region and produces one result on the response queue.
//   Results leave through rsp_empty/rsp_pop: the oldest result sits on the rsp_
//   ports while rsp_empty is low and is taken when rsp_pop is high.
//   The user writes the row length through csr_valid/csr_ready/csr_region_columns
//   only while the block is idle, which goes unchecked; csr_ready is always high.
// Throughput: one pixel per cycle unless the queue is full, set by the single
//   read port of the line buffer, which is read one pixel ahead; the first cycle
//   after reset and a row length write that moves the current column each cost
//   one cycle of full. Each result passes through the queue, snapshot, partial
//   sums and result register after its last pixel is accepted.
// Reset clears the raster position, counters and pipeline; rsp_empty is high.
//   The line buffer needs no clearing: each region's first row writes it anew.
// When the response side stalls, pixels keep flowing into the counters; up to
//   three finished regions wait in the pipeline, and the four-entry queue
//   then fills and raises req_full.
module bit_quad_shape_statistics_top #(
   parameter int MAX_COLUMNS = bqss_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bqss_pkg::PIXEL_W-1:0]        req_pixel,
   input  logic                                req_last_pixel,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_none,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_one,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_two_adjacent,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_three,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_four,
   output logic [bqss_pkg::CNT_W-1:0]          rsp_count_diagonal,
   output logic [bqss_pkg::AREA_W-1:0]         rsp_area_estimate,
   output logic [bqss_pkg::PERIM_W-1:0]        rsp_perimeter_estimate,
   output logic signed [bqss_pkg::EULER_W-1:0] rsp_euler_number,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqss_pkg::REGION_W-1:0]       csr_region_columns
);
   import bqss_pkg::*;

   logic [REGION_W-1:0] region_columns_ff, region_columns_in;
   qstat_type           q_stat;
   logic                q_push;
   logic                q_pop;
   win_type             q_entry;
   win_type             q_head;

   // configuration register
   assign csr_ready         = 1'b1;
   assign region_columns_in = (csr_valid && csr_ready) ? csr_region_columns
                                                       : region_columns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_columns_ff <= REGION_W'(REGION_RESET);
      end else begin
         region_columns_ff <= region_columns_in;
      end
   end

   // front end
   bqss_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel      (req_pixel),
      .req_last_pixel (req_last_pixel),
      .region_columns (region_columns_ff),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   // queue between the two ends
   bqss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // back end
   bqss_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (q_head),
      .q_stat                 (q_stat),
      .q_pop                  (q_pop),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_count_none         (rsp_count_none),
      .rsp_count_one          (rsp_count_one),
      .rsp_count_two_adjacent (rsp_count_two_adjacent),
      .rsp_count_three        (rsp_count_three),
      .rsp_count_four         (rsp_count_four),
      .rsp_count_diagonal     (rsp_count_diagonal),
      .rsp_area_estimate      (rsp_area_estimate),
      .rsp_perimeter_estimate (rsp_perimeter_estimate),
      .rsp_euler_number       (rsp_euler_number)
   );

`ifndef SYNTH
   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("request pushed into full queue");

   // the back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // no result is offered right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result offered after reset");

   // an accepted request always reaches the queue when it carries a last pixel
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_last_pixel) |-> q_push)
      else $error("last pixel not queued");
`endif

endmodule

/* tb/bit_quad_shape_statistics_top_tb.sv */
// self-checking testbench for the bit-quad shape statistics block
module bit_quad_shape_statistics_top_tb;
   import bqss_pkg::*;

   localparam int     CYCLE_LIMIT  = 200_000;
   localparam int     SETTLE_WAIT  = 8;
   localparam int     HOLD_CYCLES  = 300;
   localparam longint PERIM_LIMIT  = (longint'(1) << PERIM_W) - 1;
   localparam longint EULER_HI     = (longint'(1) << (EULER_W - 1)) - 1;
   localparam longint EULER_LO     = -(longint'(1) << (EULER_W - 1));

   // one pixel request waiting to be offered
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } pixel_req_type;

   // statistics of one finished region
   typedef struct {
      logic [CNT_W-1:0]          cnt_none;
      logic [CNT_W-1:0]          cnt_one;
      logic [CNT_W-1:0]          cnt_two_adj;
      logic [CNT_W-1:0]          cnt_three;
      logic [CNT_W-1:0]          cnt_four;
      logic [CNT_W-1:0]          cnt_diag;
      logic [AREA_W-1:0]         area;
      logic [PERIM_W-1:0]        perim;
      logic signed [EULER_W-1:0] euler;
   } region_stats_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [PIXEL_W-1:0]          req_pixel = '0;
   logic                        req_last_pixel = 1'b0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [CNT_W-1:0]            rsp_count_none;
   logic [CNT_W-1:0]            rsp_count_one;
   logic [CNT_W-1:0]            rsp_count_two_adjacent;
   logic [CNT_W-1:0]            rsp_count_three;
   logic [CNT_W-1:0]            rsp_count_four;
   logic [CNT_W-1:0]            rsp_count_diagonal;
   logic [AREA_W-1:0]           rsp_area_estimate;
   logic [PERIM_W-1:0]          rsp_perimeter_estimate;
   logic signed [EULER_W-1:0]   rsp_euler_number;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [REGION_W-1:0]         csr_region_columns = '0;

   // stimulus and scoreboard storage
   pixel_req_type    pixel_backlog[$];
   region_stats_type pending_stats[$];
   int               fault_count = 0;
   int               cycle_count = 0;

   // run control, written by the sequencing block only
   bit steady_flow    = 1'b0;
   bit want_long_hold = 1'b0;

   // predictor state
   logic             line_bits [DEF_MAX_COLUMNS];
   logic             left_now     = 1'b0;
   logic             left_above   = 1'b0;
   int unsigned      raster_col   = 0;
   logic             on_first_row = 1'b1;
   logic [CNT_W-1:0] class_tally [NUM_CLASSES];
   logic [REGION_W-1:0] row_span_reg = REGION_W'(REGION_RESET);

   // per-side idling state
   int gap_left   = 0;
   int stall_left = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   bit_quad_shape_statistics_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_pixel              (req_pixel),
      .req_last_pixel         (req_last_pixel),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_count_none         (rsp_count_none),
      .rsp_count_one          (rsp_count_one),
      .rsp_count_two_adjacent (rsp_count_two_adjacent),
      .rsp_count_three        (rsp_count_three),
      .rsp_count_four         (rsp_count_four),
      .rsp_count_diagonal     (rsp_count_diagonal),
      .rsp_area_estimate      (rsp_area_estimate),
      .rsp_perimeter_estimate (rsp_perimeter_estimate),
      .rsp_euler_number       (rsp_euler_number),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_region_columns     (csr_region_columns)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      foreach (line_bits[k]) line_bits[k] = 1'b0;
      foreach (class_tally[k]) class_tally[k] = '0;
   end

   // fold one accepted pixel into the window counts, queue the stats on the last one
   function automatic void account_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
      logic             black;
      logic             above;
      int unsigned      span;
      int unsigned      col;
      int unsigned      nblack;
      logic [CLS_W-1:0] cls;
      longint           q1, q2, q3, q4, qd, area, perim, euler;
      region_stats_type s;
      black = (pix == '0);
      span = row_span_reg;
      if (span < 2) span = 2;
      if (span > DEF_MAX_COLUMNS) span = DEF_MAX_COLUMNS;
      col = raster_col;
      if (col >= span) col = 0;
      above = line_bits[col];
      // window ending here exists once a full row lies above and one pixel to the left
      if (!on_first_row && col > 0) begin
         nblack = int'(left_above) + int'(above) + int'(left_now) + int'(black);
         unique case (nblack)
            0: cls = CLS_NONE;
            1: cls = CLS_ONE;
            2: cls = ((left_above && black) || (above && left_now)) ? CLS_DIAGONAL
                                                                     : CLS_TWO_ADJ;
            3: cls = CLS_THREE;
            default: cls = CLS_FOUR;
         endcase
         if (class_tally[cls] != CNT_MAX) class_tally[cls] = class_tally[cls] + 1'b1;
      end
      left_above = above;
      left_now = black;
      line_bits[col] = black;
      // wrap to the next row
      if (col + 1 >= span) begin
         raster_col = 0;
         on_first_row = 1'b0;
         left_above = 1'b0;
         left_now = 1'b0;
      end else begin
         raster_col = col + 1;
      end
      if (!last) return;
      // derived values with saturation
      q1 = class_tally[CLS_ONE];
      q2 = class_tally[CLS_TWO_ADJ];
      q3 = class_tally[CLS_THREE];
      q4 = class_tally[CLS_FOUR];
      qd = class_tally[CLS_DIAGONAL];
      area = (q1 + 2 * q2 + 2 * qd + 3 * q3 + 4 * q4) / 4;
      perim = q1 + q2 + 2 * qd;
      euler = (q1 - q3 - 2 * qd) / 4;
      if (area > longint'(CNT_MAX)) area = CNT_MAX;
      if (perim > PERIM_LIMIT) perim = PERIM_LIMIT;
      if (euler > EULER_HI) euler = EULER_HI;
      if (euler < EULER_LO) euler = EULER_LO;
      s.cnt_none    = class_tally[CLS_NONE];
      s.cnt_one     = class_tally[CLS_ONE];
      s.cnt_two_adj = class_tally[CLS_TWO_ADJ];
      s.cnt_three   = class_tally[CLS_THREE];
      s.cnt_four    = class_tally[CLS_FOUR];
      s.cnt_diag    = class_tally[CLS_DIAGONAL];
      s.area        = area[AREA_W-1:0];
      s.perim       = perim[PERIM_W-1:0];
      s.euler       = euler[EULER_W-1:0];
      pending_stats.push_back(s);
      // region done, start over
      foreach (class_tally[k]) class_tally[k] = '0;
      raster_col = 0;
      on_first_row = 1'b1;
      left_above = 1'b0;
      left_now = 1'b0;
   endfunction

   // driver: note accepted requests and register writes at the rising edge
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) row_span_reg = csr_region_columns;
      if (!reset && req_push && !req_full) begin
         account_pixel(req_pixel, req_last_pixel);
         void'(pixel_backlog.pop_front());
      end
   end

   // driver: offer the oldest pending pixel, with random gaps
   always @(negedge clock) begin
      if (reset || pixel_backlog.size() == 0) begin
         req_push <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_push <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
         gap_left = $urandom_range(0, 12);
         req_push <= 1'b0;
      end else begin
         req_push <= 1'b1;
         req_pixel <= pixel_backlog[0].pixel;
         req_last_pixel <= pixel_backlog[0].last;
      end
   end

   // receiver: pop with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else if (want_long_hold && !hold_done) begin
         hold_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic compare_field(input string label, input longint got, input longint want);
      if (got != want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fault_count = fault_count + 1;
      end
   endtask

   // monitor: check each popped result against the oldest expected stats
   always @(posedge clock) begin
      region_stats_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_stats.size() == 0) begin
            $display("%0t: result with none expected, actual area %0d euler %0d",
                     $time, rsp_area_estimate, rsp_euler_number);
            fault_count = fault_count + 1;
         end else begin
            want = pending_stats.pop_front();
            compare_field("count_none", rsp_count_none, want.cnt_none);
            compare_field("count_one", rsp_count_one, want.cnt_one);
            compare_field("count_two_adjacent", rsp_count_two_adjacent, want.cnt_two_adj);
            compare_field("count_three", rsp_count_three, want.cnt_three);
            compare_field("count_four", rsp_count_four, want.cnt_four);
            compare_field("count_diagonal", rsp_count_diagonal, want.cnt_diag);
            compare_field("area_estimate", rsp_area_estimate, want.area);
            compare_field("perimeter_estimate", rsp_perimeter_estimate, want.perim);
            compare_field("euler_number", rsp_euler_number, want.euler);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // write the row length through the register channel
   task automatic write_columns(input logic [REGION_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_region_columns <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every request is in and every result is out, then let the pipe settle
   task automatic drain();
      while (pixel_backlog.size() != 0 || pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // queue a small region from a black mask, first pixel in the top bit
   task automatic queue_mask(input logic [31:0] mask, input int n);
      pixel_req_type item;
      for (int i = 0; i < n; i++) begin
         item.pixel = mask[n - 1 - i] ? 8'h00 : (8'hFF >> (i % 8));
         item.last = (i == n - 1);
         pixel_backlog.push_back(item);
      end
   endtask

   // sequencing
   initial begin
      int unsigned   span_code;
      int unsigned   eff;
      int unsigned   len;
      int unsigned   added;
      int unsigned   budget;
      int unsigned   pick;
      pixel_req_type item;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single row under the reset row length
      queue_mask(32'b01, 2);
      drain();
      // five columns, three rows: every class but two-adjacent
      write_columns(9'd5);
      queue_mask(32'b11000_11100_01010, 15);
      drain();
      // row length zero acts as two: two-adjacent and one-black windows
      write_columns(9'd0);
      queue_mask(32'b10_10_00, 6);
      drain();
      // row length one, region of a single pixel
      write_columns(9'd1);
      queue_mask(32'b1, 1);
      drain();

      // random regions, one row length per phase; the last phase runs without idling
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 9) steady_flow = 1'b1;
         if (phase == 4) begin
            span_code = 2;
            want_long_hold = 1'b1;
         end else begin
            pick = $urandom_range(0, 39);
            if (pick == 0) span_code = $urandom_range(0, 1);
            else if (pick == 1) span_code = $urandom_range(257, 511);
            else if (pick == 2) span_code = $urandom_range(41, 256);
            else if (pick < 8) span_code = $urandom_range(9, 40);
            else span_code = $urandom_range(2, 8);
         end
         write_columns(span_code[REGION_W-1:0]);
         eff = (span_code < 2) ? 2 : (span_code > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                                    : span_code;
         budget = (phase == 4) ? 48 : 20;
         added = 0;
         while (added < budget) begin
            if (phase == 4) len = $urandom_range(1, 4);
            else if (eff > 40) len = eff + $urandom_range(1, 8);
            else begin
               len = eff * $urandom_range(1, 5);
               // broken region: last may arrive mid-row
               if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
            end
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(0, 19);
               if (pick < 9) item.pixel = 8'h00;
               else if (pick < 11) item.pixel = 8'hFF;
               else item.pixel = 8'($urandom_range(1, 255));
               item.last = (i == len - 1);
               pixel_backlog.push_back(item);
            end
            added = added + len;
         end
         drain();
      end

      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/bqss_pkg.sv
hdl/bqss_ram.sv
hdl/bqss_front.sv
hdl/bqss_queue.sv
hdl/bqss_back.sv
hdl/bit_quad_shape_statistics_top.sv
tb/bit_quad_shape_statistics_top_tb.sv
